// File: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/wcr_pkg.sv
// ----------------------------------------------------------------------------
// wcr_pkg
// Shared types, constants and the keypad code decoder of the Wiegand receiver.
// ----------------------------------------------------------------------------
package wcr_pkg;

	localparam int KEY_SLOTS_DEF = 5;
	localparam logic [15:0] GAP_LIMIT_RST = 16'd5;
	localparam logic [4:0] KEY_BITS = 5'd8;
	localparam logic [4:0] CARD_BITS = 5'd26;
	localparam int SHIFT_W = 27;
	localparam int CNT_W = 5;

	typedef enum logic {
		OP_PULSE = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef struct packed {
		op_t operation;
		logic d0_pulse;
		logic d1_pulse;
		logic [15:0] gap_ticks;
	} req_t;

	typedef struct packed {
		logic [23:0] card_id;
		logic card_ready;
		logic keys_done;
		logic aux_ready;
		logic [3:0] key_first;
		logic [3:0] key_second;
		logic [3:0] key_third;
		logic [3:0] key_fourth;
		logic [3:0] key_fifth;
		logic [2:0] keys_seen;
		logic frame_error;
	} rsp_t;

	// low nibble n with high nibble ~n and n up to 11 is a key
	function automatic logic key_code_ok(input logic [7:0] code);
		return (code[7:4] == ~code[3:0]) && (code[3:0] <= 4'd11);
	endfunction

endpackage

// File: rtl/wcr_in_stage.sv
// ----------------------------------------------------------------------------
// wcr_in_stage
// Input register: captures one request and holds it until the core takes it.
// ----------------------------------------------------------------------------
module wcr_in_stage
	import wcr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic vld_s1,
	output req_t req_s1,
	input  logic take_s1
);

	logic load;

	assign req_ready = !vld_s1 || take_s1;
	assign load = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= 1'b1;
		end else if (take_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			req_s1 <= req;
		end
	end

endmodule

// File: rtl/wcr_core.sv
// ----------------------------------------------------------------------------
// wcr_core
// Receiver state, gap limit register and the single-pass update of one request.
// ----------------------------------------------------------------------------
module wcr_core
	import wcr_pkg::*;
#(
	parameter int KEY_SLOTS = KEY_SLOTS_DEF
)
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic step,
	input  req_t req_s1,
	output rsp_t rsp_nxt
);

	localparam int SLOT_W = $clog2(KEY_SLOTS + 1);
	localparam int IDX_W = $clog2(KEY_SLOTS);

	logic [15:0] gap_limit_q;
	logic [SHIFT_W-1:0] shift_q, shift_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic last_key_q, last_key_d;
	logic [23:0] card_q, card_d;
	logic [2:0] status_q, status_d;
	logic [3:0] keys_q [KEY_SLOTS];
	logic [3:0] keys_d [KEY_SLOTS];
	logic err;

	always_comb begin
		shift_d = shift_q;
		cnt_d = cnt_q;
		slot_d = slot_q;
		last_key_d = last_key_q;
		card_d = card_q;
		status_d = status_q;
		keys_d = keys_q;
		err = 1'b0;
		if (req_s1.operation == OP_CLEAR) begin
			shift_d = '0;
			cnt_d = '0;
			slot_d = '0;
			last_key_d = 1'b0;
			card_d = '0;
			status_d = '0;
			keys_d = '{default: 4'd0};
		end else begin
			if (last_key_q) begin
				last_key_d = 1'b0;
				if (req_s1.gap_ticks < gap_limit_q) begin
					slot_d = '0;
					keys_d = '{default: 4'd0};
				end else begin
					shift_d = '0;
					cnt_d = '0;
				end
			end
			if (req_s1.d0_pulse) begin
				shift_d = {shift_d[SHIFT_W-2:0], 1'b0};
				cnt_d = cnt_d + CNT_W'(1);
			end
			if (req_s1.d1_pulse) begin
				shift_d = {shift_d[SHIFT_W-2:0], 1'b1};
				cnt_d = cnt_d + CNT_W'(1);
			end
			if (cnt_d == KEY_BITS) begin
				// full buffer wraps to slot 0 and clears its flags before the new key
				if (slot_d >= SLOT_W'(KEY_SLOTS)) begin
					slot_d = '0;
					status_d[2:1] = 2'b00;
				end
				if (key_code_ok(shift_d[7:0])) begin
					keys_d[slot_d[IDX_W-1:0]] = shift_d[3:0];
					if (slot_d == SLOT_W'(3)) begin
						status_d[1] = 1'b1;
					end
					if (slot_d == SLOT_W'(4)) begin
						status_d[2] = 1'b1;
					end
				end
				slot_d = slot_d + SLOT_W'(1);
				last_key_d = 1'b1;
			end
			if (cnt_d == CARD_BITS) begin
				card_d = shift_d[24:1];
				status_d[0] = 1'b1;
				cnt_d = '0;
				shift_d = '0;
			end
			if (cnt_d > CARD_BITS) begin
				shift_d = '0;
				cnt_d = '0;
				slot_d = '0;
				last_key_d = 1'b0;
				card_d = '0;
				status_d = '0;
				keys_d = '{default: 4'd0};
				err = 1'b1;
			end
		end
	end

	always_comb begin
		rsp_nxt.card_id = card_d;
		rsp_nxt.card_ready = status_d[0];
		rsp_nxt.keys_done = status_d[1];
		rsp_nxt.aux_ready = status_d[2];
		rsp_nxt.key_first = keys_d[0];
		rsp_nxt.key_second = keys_d[1];
		rsp_nxt.key_third = keys_d[2];
		rsp_nxt.key_fourth = keys_d[3];
		rsp_nxt.key_fifth = keys_d[4];
		rsp_nxt.keys_seen = (slot_d > SLOT_W'(7)) ? 3'd7 : 3'(slot_d);
		rsp_nxt.frame_error = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= GAP_LIMIT_RST;
		end else if (cfg_we) begin
			gap_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			cnt_q <= '0;
			slot_q <= '0;
			last_key_q <= 1'b0;
			card_q <= '0;
			status_q <= '0;
			keys_q <= '{default: 4'd0};
		end else if (step) begin
			shift_q <= shift_d;
			cnt_q <= cnt_d;
			slot_q <= slot_d;
			last_key_q <= last_key_d;
			card_q <= card_d;
			status_q <= status_d;
			keys_q <= keys_d;
		end
	end

endmodule

// File: rtl/wcr_out_stage.sv
// ----------------------------------------------------------------------------
// wcr_out_stage
// Result register: holds a finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module wcr_out_stage
	import wcr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic vld_s1,
	output logic take_s1,
	input  rsp_t rsp_nxt,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	assign take_s1 = vld_s1 && (!rsp_valid || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (take_s1) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			rsp <= rsp_nxt;
		end
	end

endmodule

// File: rtl/wiegand_card_and_keypad_receiver_top.sv
// a result is valid once its request has passed the input register, then
// the result register, which loads after the single-pass update
// throughput: one request per cycle if rsp_ready; state update is combinational
// reset: arst_n clears all receiver state, the gap limit returns to 5 ticks
// a stalled result holds the update, the input register takes one more request
// ----------------------------------------------------------------------------
// wiegand_card_and_keypad_receiver_top
// Wiegand receiver for 26-bit card frames and 8-bit keypad codes.
// ----------------------------------------------------------------------------
module wiegand_card_and_keypad_receiver_top
	import wcr_pkg::*;
#(
	parameter int KEY_SLOTS = KEY_SLOTS_DEF
)
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic vld_s1;
	req_t req_s1;
	logic take_s1;
	rsp_t rsp_nxt;

	wcr_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.vld_s1(vld_s1),
		.req_s1(req_s1),
		.take_s1(take_s1)
	);

	wcr_core #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.step(take_s1),
		.req_s1(req_s1),
		.rsp_nxt(rsp_nxt)
	);

	wcr_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.vld_s1(vld_s1),
		.take_s1(take_s1),
		.rsp_nxt(rsp_nxt),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

endmodule

// File: rtl/wcr_checker.sv
// ----------------------------------------------------------------------------
// wcr_checker
// Port-level checks of the Wiegand receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wcr_checker
	import wcr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// a stalled result stays
	`ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`ASSERT_NXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp))
	// with no result pending the input side never stalls
	`ASSERT_IMP(a_req_free, clk, arst_n, !rsp_valid, req_ready)
	// an overlong frame leaves the receiver empty
	`ASSERT_IMP(a_err_clear, clk, arst_n, rsp_valid && rsp.frame_error,
		rsp.card_id == 24'd0 && !rsp.card_ready && !rsp.keys_done &&
		!rsp.aux_ready && rsp.keys_seen == 3'd0 &&
		rsp.key_first == 4'd0 && rsp.key_fifth == 4'd0)

endmodule

bind wiegand_card_and_keypad_receiver_top wcr_checker u_chk (.*);

// File: verif/wiegand_card_and_keypad_receiver_top_test.sv
// ----------------------------------------------------------------------------
// wiegand_card_and_keypad_receiver_top_test
// Self-checking bench for the Wiegand receiver. Pulse and clear requests go in
// with random handshake gaps on both sides, every result is predicted from a
// local model of the receiver and compared field by field.
// ----------------------------------------------------------------------------
module wiegand_card_and_keypad_receiver_top_test;
	import wcr_pkg::*;

	localparam int NUM_SLOTS = KEY_SLOTS_DEF;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	wiegand_card_and_keypad_receiver_top #(.KEY_SLOTS(NUM_SLOTS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// receiver model state
	logic [15:0] gap_limit;
	logic [26:0] rx_shift;
	int unsigned rx_count;
	int unsigned slot_idx;
	bit after_key;
	bit card_flag;
	bit keys_flag;
	bit aux_flag;
	logic [23:0] card_q;
	logic [3:0] key_buf [NUM_SLOTS];

	rsp_t expected_q [$];
	int unsigned fail_count = 0;
	int unsigned request_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned cards_seen = 0;
	int unsigned key_frames = 0;
	int unsigned overruns_seen = 0;
	int unsigned clears_seen = 0;
	bit steady_mode = 1'b0;
	bit hold_request = 1'b0;

	function automatic void clear_rx();
		rx_shift = '0;
		rx_count = 0;
		slot_idx = 0;
		after_key = 1'b0;
		card_q = '0;
		card_flag = 1'b0;
		keys_flag = 1'b0;
		aux_flag = 1'b0;
		foreach (key_buf[i]) key_buf[i] = '0;
	endfunction

	function automatic void take_key_frame();
		logic [7:0] code;
		code = rx_shift[7:0];
		if (slot_idx >= NUM_SLOTS) begin
			slot_idx = 0;
			keys_flag = 1'b0;
			aux_flag = 1'b0;
		end
		if ((code[7:4] ^ code[3:0]) == 4'hF && code[3:0] < 4'd12) begin
			key_buf[slot_idx] = code[3:0];
			if (slot_idx == 3) keys_flag = 1'b1;
			if (slot_idx == 4) aux_flag = 1'b1;
		end
		slot_idx++;
		after_key = 1'b1;
		key_frames++;
	endfunction

	function automatic rsp_t predict_event(input req_t r);
		rsp_t res;
		bit overrun;
		overrun = 1'b0;
		if (r.operation == OP_CLEAR) begin
			clear_rx();
			clears_seen++;
		end else begin
			if (after_key) begin
				after_key = 1'b0;
				// short gap: the key bits go on as a card frame
				if (r.gap_ticks < gap_limit) begin
					slot_idx = 0;
					foreach (key_buf[i]) key_buf[i] = '0;
				end else begin
					rx_shift = '0;
					rx_count = 0;
				end
			end
			if (r.d0_pulse) begin
				rx_shift = {rx_shift[25:0], 1'b0};
				rx_count++;
			end
			if (r.d1_pulse) begin
				rx_shift = {rx_shift[25:0], 1'b1};
				rx_count++;
			end
			if (rx_count == KEY_BITS) take_key_frame();
			if (rx_count == CARD_BITS) begin
				card_q = rx_shift[24:1];
				card_flag = 1'b1;
				rx_count = 0;
				rx_shift = '0;
				cards_seen++;
			end
			if (rx_count > CARD_BITS) begin
				clear_rx();
				overrun = 1'b1;
				overruns_seen++;
			end
		end
		res.card_id = card_q;
		res.card_ready = card_flag;
		res.keys_done = keys_flag;
		res.aux_ready = aux_flag;
		res.key_first = key_buf[0];
		res.key_second = key_buf[1];
		res.key_third = key_buf[2];
		res.key_fourth = key_buf[3];
		res.key_fifth = key_buf[4];
		res.keys_seen = (slot_idx > 7) ? 3'd7 : 3'(slot_idx);
		res.frame_error = overrun;
		return res;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic compare_result(input rsp_t want, input rsp_t got);
		check_field("card_id", 32'(want.card_id), 32'(got.card_id));
		check_field("card_ready", 32'(want.card_ready), 32'(got.card_ready));
		check_field("keys_done", 32'(want.keys_done), 32'(got.keys_done));
		check_field("aux_ready", 32'(want.aux_ready), 32'(got.aux_ready));
		check_field("key_first", 32'(want.key_first), 32'(got.key_first));
		check_field("key_second", 32'(want.key_second), 32'(got.key_second));
		check_field("key_third", 32'(want.key_third), 32'(got.key_third));
		check_field("key_fourth", 32'(want.key_fourth), 32'(got.key_fourth));
		check_field("key_fifth", 32'(want.key_fifth), 32'(got.key_fifth));
		check_field("keys_seen", 32'(want.keys_seen), 32'(got.keys_seen));
		check_field("frame_error", 32'(want.frame_error), 32'(got.frame_error));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					compare_result(expected_q.pop_front(), rsp);
				end
			end
			if (req_valid && req_ready) begin
				expected_q.push_back(predict_event(req));
				request_count++;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("wiegand_card_and_keypad_receiver_top_test: errors");
			$finish;
		end
	end

	function automatic int unsigned pick_pause();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side: random stalls, a long hold on request
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				rsp_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				rsp_ready = 1'b1;
			end else if (steady_mode || stall_left == 0) begin
				rsp_ready = 1'b1;
				if (!steady_mode && $urandom_range(0, 3) == 0) stall_left = pick_pause();
			end else begin
				rsp_ready = 1'b0;
				stall_left--;
			end
		end
	end

	function automatic logic [15:0] short_gap();
		if (gap_limit == 0) return 16'd0;
		if ($urandom_range(0, 3) != 0)
			return 16'($urandom_range(0, (gap_limit > 16) ? 15 : gap_limit - 1));
		return 16'($urandom_range(0, gap_limit - 1));
	endfunction

	function automatic logic [15:0] long_gap();
		return 16'($urandom_range(gap_limit, 16'hFFFF));
	endfunction

	function automatic logic [15:0] any_gap();
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	function automatic logic [7:0] key_code(input logic [3:0] n);
		return {~n, n};
	endfunction

	function automatic logic [7:0] pick_key_byte();
		case ($urandom_range(0, 9))
			0: return 8'($urandom);
			1: return key_code(4'($urandom_range(12, 15)));
			default: return key_code(4'($urandom_range(0, 11)));
		endcase
	endfunction

	task automatic send_event(input op_t op, input logic d0, input logic d1,
			input logic [15:0] gap);
		int unsigned pause;
		pause = steady_mode ? 0 : pick_pause();
		if (pause != 0) begin
			req_valid = 1'b0;
			repeat (pause) @(negedge clk);
		end
		req = '{operation: op, d0_pulse: d0, d1_pulse: d1, gap_ticks: gap};
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	// msb first, one pulse per request, but card frames sometimes pair a 0 and a 1 in one request
	task automatic send_frame(input logic [31:0] bits, input int nbits,
			input logic [15:0] first_gap, input bit as_card);
		int i;
		logic [15:0] gap;
		i = nbits - 1;
		while (i >= 0) begin
			gap = (i == nbits - 1) ? first_gap : (as_card ? short_gap() : any_gap());
			if (as_card && i > 0 && !bits[i] && bits[i-1] && $urandom_range(0, 7) == 0) begin
				send_event(OP_PULSE, 1'b1, 1'b1, gap);
				i -= 2;
			end else begin
				send_event(OP_PULSE, !bits[i], bits[i], gap);
				i--;
			end
		end
	endtask

	task automatic wait_drained();
		req_valid = 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_gap_limit(input logic [15:0] value);
		wait_drained();
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		gap_limit = value;
	endtask

	task automatic test_directed_edges();
		send_event(OP_CLEAR, 1'b1, 1'b1, 16'hFFFF);
		send_event(OP_PULSE, 1'b0, 1'b0, 16'h0000);
		send_event(OP_PULSE, 1'b1, 1'b1, 16'hFFFF);
		send_event(OP_CLEAR, 1'b0, 1'b0, 16'h0000);
		send_frame({24'd0, key_code(4'd0)}, int'(KEY_BITS), 16'hFFFF, 1'b0);
		send_frame({24'd0, key_code(4'd11)}, int'(KEY_BITS), 16'hFFFF, 1'b0);
		// short gap with no pulse: keys dropped, same eight bits taken again
		send_event(OP_PULSE, 1'b0, 1'b0, 16'h0000);
		wait_drained();
	endtask

	task automatic test_keypad_entry(input int sequences);
		int nkeys;
		repeat (sequences) begin
			nkeys = $urandom_range(1, 7);
			repeat (nkeys)
				send_frame({24'd0, pick_key_byte()}, int'(KEY_BITS), long_gap(), 1'b0);
			if ($urandom_range(0, 3) == 0)
				send_event(OP_CLEAR, 1'($urandom), 1'($urandom), any_gap());
		end
	endtask

	task automatic test_card_frames(input int frames);
		logic [31:0] bits;
		repeat (frames) begin
			bits = $urandom;
			case ($urandom_range(0, 9))
				0, 1: begin
					send_frame({24'd0, pick_key_byte()}, int'(KEY_BITS), long_gap(), 1'b0);
					send_frame(bits, int'(CARD_BITS - KEY_BITS), short_gap(), 1'b1);
				end
				2, 3: begin
					send_frame(bits, $urandom_range(27, 30), long_gap(), 1'b1);
					send_event(OP_CLEAR, 1'b0, 1'b0, any_gap());
				end
				4: begin
					send_frame(bits, $urandom_range(9, 25), long_gap(), 1'b1);
					send_event(OP_CLEAR, 1'b0, 1'b0, any_gap());
				end
				default: send_frame(bits, int'(CARD_BITS), long_gap(), 1'b1);
			endcase
		end
	endtask

	task automatic test_noise(input int count);
		op_t op;
		logic [15:0] gap;
		repeat (count) begin
			op = ($urandom_range(0, 9) == 0) ? OP_CLEAR : OP_PULSE;
			case ($urandom_range(0, 3))
				0: gap = 16'h0000;
				1: gap = 16'hFFFF;
				default: gap = any_gap();
			endcase
			send_event(op, 1'($urandom), 1'($urandom), gap);
		end
		send_event(OP_CLEAR, 1'b0, 1'b0, any_gap());
	endtask

	task automatic test_gap_limit_sweep();
		logic [15:0] limits [5];
		limits = '{16'd0, 16'hFFFF, 16'd1, 16'd0, GAP_LIMIT_RST};
		limits[3] = 16'($urandom_range(2, 65534));
		foreach (limits[i]) begin
			write_gap_limit(limits[i]);
			test_keypad_entry(1);
			test_card_frames(2);
		end
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_request = 1'b1;
		repeat (5)
			send_frame({24'd0, pick_key_byte()}, int'(KEY_BITS), long_gap(), 1'b0);
		wait_drained();
		steady_mode = 1'b1;
		test_keypad_entry(3);
		test_card_frames(2);
		steady_mode = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req = '0;
		gap_limit = GAP_LIMIT_RST;
		clear_rx();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_edges();
		test_keypad_entry(10);
		test_card_frames(10);
		test_noise(150);
		test_gap_limit_sweep();
		test_backpressure();
		wait_drained();

		$display("%0d requests: %0d cards, %0d key frames, %0d overlong frames, %0d clears",
			request_count, cards_seen, key_frames, overruns_seen, clears_seen);
		$display("gap limits 0, 1, 5, 65535 and random; long result hold and gapless runs");
		if (fail_count == 0) begin
			$display("wiegand_card_and_keypad_receiver_top_test: clean");
		end else begin
			$display("wiegand_card_and_keypad_receiver_top_test: errors");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/wcr_pkg.sv
rtl/wcr_in_stage.sv
rtl/wcr_core.sv
rtl/wcr_out_stage.sv
rtl/wiegand_card_and_keypad_receiver_top.sv
rtl/wcr_checker.sv
verif/wiegand_card_and_keypad_receiver_top_test.sv
